@@ design/crvg_pkg.sv @@
// ----------------------------------------------------------------------------
// crvg_pkg
// Shared codes, geometry and constants of the character raster generator.
// ----------------------------------------------------------------------------
`default_nettype none

package crvg_pkg;

   // input item kinds
   localparam logic [1:0] KIND_BUS_WRITE   = 2'd0;
   localparam logic [1:0] KIND_BUS_READ    = 2'd1;
   localparam logic [1:0] KIND_PIXEL_TICK  = 2'd2;
   localparam logic [1:0] KIND_FETCH_REPLY = 2'd3;

   // result item kinds
   localparam logic [1:0] RES_READ_DATA = 2'd0;
   localparam logic [1:0] RES_FETCH     = 2'd1;
   localparam logic [1:0] RES_PIXEL     = 2'd2;

   // register selects
   localparam logic [3:0] REG_CONTROL_ONE = 4'd0;
   localparam logic [3:0] REG_CONTROL_TWO = 4'd1;
   localparam logic [3:0] REG_RASTER      = 4'd2;
   localparam logic [3:0] REG_BACKGROUND  = 4'd3;
   localparam logic [3:0] REG_BORDER      = 4'd4;
   localparam logic [3:0] REG_SCREEN_BASE = 4'd5;
   localparam logic [3:0] REG_GLYPH_BASE  = 4'd6;

   // fetch phases
   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_SCREEN = 2'd1;
   localparam logic [1:0] PHASE_GLYPH  = 2'd2;

   // raster geometry
   localparam logic [7:0] SCREEN_WIDTH  = 8'd232;
   localparam logic [8:0] SCREEN_HEIGHT = 9'd272;
   localparam logic [7:0] BORDER_LEFT   = 8'd48;
   localparam logic [7:0] BORDER_RIGHT  = 8'd8;
   localparam logic [8:0] BORDER_TOP    = 9'd40;
   localparam logic [8:0] BORDER_BOTTOM = 9'd48;

   localparam logic [15:0] CELLS_PER_ROW     = 16'd22;
   localparam logic [15:0] SCREEN_BASE_RESET = 16'h1E00;
   localparam logic [15:0] GLYPH_BASE_RESET  = 16'h1000;
   localparam logic [7:0]  BASE_MASK         = 8'hF0;
   localparam logic [7:0]  UNMAPPED_READ     = 8'hFF;
   localparam logic [3:0]  PATTERN_COLOR     = 4'd1;

endpackage : crvg_pkg

`default_nettype wire

@@ design/crvg_if.sv @@
// ----------------------------------------------------------------------------
// crvg channel interfaces
// Valid/ready channels for request items, result items and the control write.
// ----------------------------------------------------------------------------
`default_nettype none

interface crvg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] bus_addr;
   logic [7:0]  data;

   modport source (output valid, output kind, output bus_addr, output data, input ready);
   modport sink   (input valid, input kind, input bus_addr, input data, output ready);
endinterface : crvg_req_if

interface crvg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  read_data;
   logic [15:0] fetch_addr;
   logic [7:0]  pixel_x;
   logic [8:0]  pixel_y;
   logic [3:0]  pixel_color;

   modport source (output valid, output result_kind, output read_data, output fetch_addr,
                   output pixel_x, output pixel_y, output pixel_color, input ready);
   modport sink   (input valid, input result_kind, input read_data, input fetch_addr,
                   input pixel_x, input pixel_y, input pixel_color, output ready);
endinterface : crvg_rsp_if

interface crvg_csr_if;
   logic valid;
   logic ready;
   logic fetch_enable;

   modport source (output valid, output fetch_enable, input ready);
   modport sink   (input valid, input fetch_enable, output ready);
endinterface : crvg_csr_if

`default_nettype wire

@@ design/character_raster_video_generator.sv @@
// ----------------------------------------------------------------------------
// character_raster_video_generator
// Character-mode raster generator with register file and fetch sequencing.
// ----------------------------------------------------------------------------
// Takes one request item per clock. Each item is decoded against the register
// file and beam state in the cycle it is accepted, and its result (read data,
// a memory fetch request or a pixel) lands in a single output register the
// next cycle; bus writes and unanswered replies produce nothing. The request
// side stays ready whenever that output register is empty or being drained,
// so the sustained rate is one item per cycle, bounded by the result register.
// An active pixel takes two fetch round trips through the reply input before
// it is emitted; a tick in the meantime abandons the pending pixel.
`default_nettype none

module character_raster_video_generator
   import crvg_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   crvg_req_if.sink   req_chan,
   crvg_rsp_if.source rsp_chan,
   crvg_csr_if.sink   csr_chan
);

   logic        fetch_enable_ff;
   logic [7:0]  control_one_ff, control_two_ff, raster_ff;
   logic [3:0]  background_ff, border_ff;
   logic [15:0] screen_base_ff, glyph_base_ff;
   logic [7:0]  column_ff;
   logic [8:0]  line_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  pend_column_ff;
   logic [8:0]  pend_line_ff;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_read_ff, out_read_in;
   logic [15:0] out_addr_ff, out_addr_in;
   logic [7:0]  out_x_ff, out_x_in;
   logic [8:0]  out_y_ff, out_y_in;
   logic [3:0]  out_color_ff, out_color_in;

   logic        accept;
   logic [3:0]  reg_sel;
   logic        in_border;
   logic [7:0]  col_off;
   logic [8:0]  line_off;
   logic [15:0] screen_addr;
   logic [7:0]  pend_col_off;
   logic [8:0]  pend_line_off;
   logic [15:0] glyph_addr;
   logic [2:0]  bit_sel;
   logic        pattern_bit;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign reg_sel        = req_chan.bus_addr[3:0];

   assign in_border = (column_ff < BORDER_LEFT) || (column_ff >= SCREEN_WIDTH - BORDER_RIGHT) ||
                      (line_ff < BORDER_TOP) || (line_ff >= SCREEN_HEIGHT - BORDER_BOTTOM);

   assign col_off     = column_ff - BORDER_LEFT;
   assign line_off    = line_ff - BORDER_TOP;
   assign screen_addr = screen_base_ff + 16'(line_off[8:3]) * CELLS_PER_ROW
                        + 16'(col_off[7:3]);

   assign pend_col_off  = pend_column_ff - BORDER_LEFT;
   assign pend_line_off = pend_line_ff - BORDER_TOP;
   assign glyph_addr    = glyph_base_ff + {5'd0, req_chan.data, 3'd0}
                          + 16'(pend_line_off[2:0]);
   assign bit_sel       = 3'd7 - pend_col_off[2:0];
   assign pattern_bit   = req_chan.data[bit_sel];

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_read_in  = out_read_ff;
      out_addr_in  = out_addr_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      if (accept) begin
         out_valid_in = 1'b0;
         out_read_in  = 8'd0;
         out_addr_in  = 16'd0;
         out_x_in     = 8'd0;
         out_y_in     = 9'd0;
         out_color_in = 4'd0;
         case (req_chan.kind)
            KIND_BUS_READ: begin
               out_valid_in = 1'b1;
               out_kind_in  = RES_READ_DATA;
               case (reg_sel)
                  REG_CONTROL_ONE: out_read_in = control_one_ff;
                  REG_CONTROL_TWO: out_read_in = control_two_ff;
                  REG_RASTER:      out_read_in = raster_ff;
                  REG_BACKGROUND:  out_read_in = {4'd0, background_ff};
                  REG_BORDER:      out_read_in = {4'd0, border_ff};
                  default:         out_read_in = UNMAPPED_READ;
               endcase
            end
            KIND_PIXEL_TICK: begin
               out_valid_in = 1'b1;
               if (in_border || !fetch_enable_ff) begin
                  out_kind_in  = RES_PIXEL;
                  out_x_in     = column_ff;
                  out_y_in     = line_ff;
                  out_color_in = in_border ? border_ff : background_ff;
               end else begin
                  out_kind_in = RES_FETCH;
                  out_addr_in = screen_addr;
               end
            end
            KIND_FETCH_REPLY: begin
               if (phase_ff == PHASE_SCREEN) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = RES_FETCH;
                  out_addr_in  = glyph_addr;
               end else if (phase_ff == PHASE_GLYPH) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = RES_PIXEL;
                  out_x_in     = pend_column_ff;
                  out_y_in     = pend_line_ff;
                  out_color_in = pattern_bit ? PATTERN_COLOR : background_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_read_ff  <= out_read_in;
      out_addr_ff  <= out_addr_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         fetch_enable_ff <= 1'b1;
         control_one_ff  <= 8'd0;
         control_two_ff  <= 8'd0;
         raster_ff       <= 8'd0;
         background_ff   <= 4'd0;
         border_ff       <= 4'd0;
         screen_base_ff  <= SCREEN_BASE_RESET;
         glyph_base_ff   <= GLYPH_BASE_RESET;
         column_ff       <= 8'd0;
         line_ff         <= 9'd0;
         phase_ff        <= PHASE_IDLE;
         pend_column_ff  <= 8'd0;
         pend_line_ff    <= 9'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            fetch_enable_ff <= csr_chan.fetch_enable;
         end
         if (accept) begin
            case (req_chan.kind)
               KIND_BUS_WRITE: begin
                  case (reg_sel)
                     REG_CONTROL_ONE: control_one_ff <= req_chan.data;
                     REG_CONTROL_TWO: control_two_ff <= req_chan.data;
                     REG_RASTER:      raster_ff      <= req_chan.data;
                     REG_BACKGROUND:  background_ff  <= req_chan.data[3:0];
                     REG_BORDER:      border_ff      <= req_chan.data[3:0];
                     REG_SCREEN_BASE:
                        screen_base_ff <= {2'd0, req_chan.data & BASE_MASK, 6'd0};
                     REG_GLYPH_BASE:
                        glyph_base_ff <= {2'd0, req_chan.data & BASE_MASK, 6'd0};
                     default: begin
                     end
                  endcase
               end
               KIND_PIXEL_TICK: begin
                  if (in_border || !fetch_enable_ff) begin
                     phase_ff <= PHASE_IDLE;
                  end else begin
                     phase_ff       <= PHASE_SCREEN;
                     pend_column_ff <= column_ff;
                     pend_line_ff   <= line_ff;
                  end
                  // advance beam
                  if (column_ff == SCREEN_WIDTH - 8'd1) begin
                     column_ff <= 8'd0;
                     line_ff   <= (line_ff == SCREEN_HEIGHT - 9'd1) ? 9'd0 : line_ff + 9'd1;
                  end else begin
                     column_ff <= column_ff + 8'd1;
                  end
               end
               KIND_FETCH_REPLY: begin
                  if (phase_ff == PHASE_SCREEN) begin
                     phase_ff <= PHASE_GLYPH;
                  end else if (phase_ff == PHASE_GLYPH) begin
                     phase_ff <= PHASE_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_kind_ff;
   assign rsp_chan.read_data   = out_read_ff;
   assign rsp_chan.fetch_addr  = out_addr_ff;
   assign rsp_chan.pixel_x     = out_x_ff;
   assign rsp_chan.pixel_y     = out_y_ff;
   assign rsp_chan.pixel_color = out_color_ff;

endmodule : character_raster_video_generator

`default_nettype wire

@@ tb/crvg_raster_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crvg_raster_checker
// Watches the request, result and control channels of the raster generator.
// Keeps its own copy of the register file, beam position and fetch sequencing,
// works out the result item due for every accepted request item and compares
// each accepted result item, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module crvg_raster_checker
   import crvg_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   crvg_req_if  req_chan,
   crvg_rsp_if  rsp_chan,
   crvg_csr_if  csr_chan,
   output int   fail_count,
   output int   awaited_count
);

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  read_data;
      logic [15:0] fetch_addr;
      logic [7:0]  pixel_x;
      logic [8:0]  pixel_y;
      logic [3:0]  pixel_color;
   } raster_result_type;

   raster_result_type awaited_results[$];

   logic        fetch_enable;
   logic [7:0]  control_one;
   logic [7:0]  control_two;
   logic [7:0]  raster_value;
   logic [3:0]  background_color;
   logic [3:0]  border_color;
   logic [15:0] screen_base;
   logic [15:0] glyph_base;
   logic [7:0]  beam_col;
   logic [8:0]  beam_line;
   logic [1:0]  fetch_phase;
   logic [7:0]  pending_col;
   logic [8:0]  pending_line;

   function automatic raster_result_type pixel_result(input logic [7:0] x,
                                                      input logic [8:0] y,
                                                      input logic [3:0] color);
      raster_result_type res;
      res             = '0;
      res.result_kind = RES_PIXEL;
      res.pixel_x     = x;
      res.pixel_y     = y;
      res.pixel_color = color;
      return res;
   endfunction

   function automatic string describe_result(input raster_result_type r);
      return $sformatf("kind %0d read %02h fetch %04h x %0d y %0d colour %0d",
                       r.result_kind, r.read_data, r.fetch_addr, r.pixel_x, r.pixel_y,
                       r.pixel_color);
   endfunction

   task automatic render_raster_item(input logic [1:0] kind, input logic [15:0] addr,
                                     input logic [7:0] data);
      raster_result_type res;
      logic [2:0]        glyph_row;
      logic [2:0]        glyph_bit;
      bit                emits;
      res   = '0;
      emits = 1'b1;
      case (kind)
         KIND_BUS_WRITE: begin
            emits = 1'b0;
            case (addr[3:0])
               REG_CONTROL_ONE: control_one      = data;
               REG_CONTROL_TWO: control_two      = data;
               REG_RASTER:      raster_value     = data;
               REG_BACKGROUND:  background_color = data[3:0];
               REG_BORDER:      border_color     = data[3:0];
               REG_SCREEN_BASE: screen_base      = {2'b00, data & BASE_MASK, 6'd0};
               REG_GLYPH_BASE:  glyph_base       = {2'b00, data & BASE_MASK, 6'd0};
               default: ;
            endcase
         end
         KIND_BUS_READ: begin
            res.result_kind = RES_READ_DATA;
            case (addr[3:0])
               REG_CONTROL_ONE: res.read_data = control_one;
               REG_CONTROL_TWO: res.read_data = control_two;
               REG_RASTER:      res.read_data = raster_value;
               REG_BACKGROUND:  res.read_data = {4'd0, background_color};
               REG_BORDER:      res.read_data = {4'd0, border_color};
               default:         res.read_data = UNMAPPED_READ;
            endcase
         end
         KIND_PIXEL_TICK: begin
            fetch_phase = PHASE_IDLE;
            if (beam_col < BORDER_LEFT || beam_col >= SCREEN_WIDTH - BORDER_RIGHT ||
                beam_line < BORDER_TOP || beam_line >= SCREEN_HEIGHT - BORDER_BOTTOM) begin
               res = pixel_result(beam_col, beam_line, border_color);
            end else if (!fetch_enable) begin
               res = pixel_result(beam_col, beam_line, background_color);
            end else begin
               res.result_kind = RES_FETCH;
               res.fetch_addr  = screen_base
                                 + 16'((beam_line - BORDER_TOP) >> 3) * CELLS_PER_ROW
                                 + 16'((beam_col - BORDER_LEFT) >> 3);
               pending_col     = beam_col;
               pending_line    = beam_line;
               fetch_phase     = PHASE_SCREEN;
            end
            // advance the beam, wrapping at the end of the line and of the frame
            if (beam_col == SCREEN_WIDTH - 1) begin
               beam_col  = '0;
               beam_line = (beam_line == SCREEN_HEIGHT - 1) ? '0 : beam_line + 1'b1;
            end else begin
               beam_col = beam_col + 1'b1;
            end
         end
         default: begin
            if (fetch_phase == PHASE_SCREEN) begin
               glyph_row       = 3'(pending_line - BORDER_TOP);
               res.result_kind = RES_FETCH;
               res.fetch_addr  = glyph_base + {5'd0, data, 3'd0} + {13'd0, glyph_row};
               fetch_phase     = PHASE_GLYPH;
            end else if (fetch_phase == PHASE_GLYPH) begin
               glyph_bit   = 3'd7 - 3'(pending_col - BORDER_LEFT);
               res         = pixel_result(pending_col, pending_line,
                                          data[glyph_bit] ? PATTERN_COLOR : background_color);
               fetch_phase = PHASE_IDLE;
            end else begin
               emits = 1'b0;
            end
         end
      endcase
      if (emits) begin
         awaited_results.push_back(res);
      end
   endtask

   task automatic check_result();
      raster_result_type seen;
      raster_result_type want;
      seen.result_kind = rsp_chan.result_kind;
      seen.read_data   = rsp_chan.read_data;
      seen.fetch_addr  = rsp_chan.fetch_addr;
      seen.pixel_x     = rsp_chan.pixel_x;
      seen.pixel_y     = rsp_chan.pixel_y;
      seen.pixel_color = rsp_chan.pixel_color;
      if (awaited_results.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: result item with none due: %s", $realtime, describe_result(seen));
         end
      end else begin
         want = awaited_results.pop_front();
         if (seen.result_kind !== want.result_kind || seen.read_data !== want.read_data ||
             seen.fetch_addr !== want.fetch_addr || seen.pixel_x !== want.pixel_x ||
             seen.pixel_y !== want.pixel_y || seen.pixel_color !== want.pixel_color) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected %s", describe_result(want));
               $display("   actual   %s", describe_result(seen));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fetch_enable     = 1'b1;
         control_one      = '0;
         control_two      = '0;
         raster_value     = '0;
         background_color = '0;
         border_color     = '0;
         screen_base      = SCREEN_BASE_RESET;
         glyph_base       = GLYPH_BASE_RESET;
         beam_col         = '0;
         beam_line        = '0;
         fetch_phase      = PHASE_IDLE;
         pending_col      = '0;
         pending_line     = '0;
         awaited_results.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_result();
         end
         if (csr_chan.valid && csr_chan.ready) begin
            fetch_enable = csr_chan.fetch_enable;
         end
         if (req_chan.valid && req_chan.ready) begin
            render_raster_item(req_chan.kind, req_chan.bus_addr, req_chan.data);
         end
      end
      awaited_count <= awaited_results.size();
   end

endmodule : crvg_raster_checker

@@ tb/tb_character_raster_video_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_character_raster_video_generator
// Drives the raster generator through register accesses and one whole frame
// of pixel ticks, answering fetch requests with random screen and glyph bytes.
// Idling and result back-pressure change from phase to phase, and so does the
// fetch enable; the checker beside the block judges every result item.
// ----------------------------------------------------------------------------
module tb_character_raster_video_generator
   import crvg_pkg::*;
();

   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int STEPS_PER_PHASE = 300;

   logic clock;
   logic reset;
   logic result_ready = 1'b0;
   int   fail_count;
   int   awaited_count;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   quiet_cycles;
   int   beam_col;
   int   beam_line;
   bit   frame_wrapped;
   bit   fetch_on;

   crvg_req_if req_chan ();
   crvg_rsp_if rsp_chan ();
   crvg_csr_if csr_chan ();

   assign rsp_chan.ready = result_ready;

   character_raster_video_generator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   crvg_raster_checker raster_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .fail_count    (fail_count),
      .awaited_count (awaited_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      result_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL character_raster_video_generator");
         $finish;
      end
   end

   function automatic bit beam_in_window();
      return beam_col >= int'(BORDER_LEFT) && beam_col < int'(SCREEN_WIDTH - BORDER_RIGHT) &&
             beam_line >= int'(BORDER_TOP) && beam_line < int'(SCREEN_HEIGHT - BORDER_BOTTOM);
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= kind;
      req_chan.bus_addr <= addr;
      req_chan.data     <= data;
      do @(posedge clock); while (!req_chan.ready);
      if (kind == KIND_PIXEL_TICK) begin
         beam_col++;
         if (beam_col == int'(SCREEN_WIDTH)) begin
            beam_col = 0;
            beam_line++;
            if (beam_line == int'(SCREEN_HEIGHT)) begin
               beam_line     = 0;
               frame_wrapped = 1'b1;
            end
         end
      end
   endtask

   task automatic send_tick();
      send_item(KIND_PIXEL_TICK, 16'($urandom), 8'($urandom));
   endtask

   task automatic send_reply();
      send_item(KIND_FETCH_REPLY, 16'($urandom), 8'($urandom));
   endtask

   task automatic send_noise();
      send_item(2'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic raster_step();
      int pick;
      int burst;
      pick  = $urandom_range(99);
      burst = 0;
      if (!beam_in_window()) begin
         burst = $urandom_range(1, 200);
      end else if (pick < 30) begin
         burst = $urandom_range(1, 40);
      end
      if (burst != 0) begin
         repeat (burst) send_tick();
      end else if (pick < 50) begin
         send_noise();
      end else begin
         send_tick();
         if (fetch_on) begin
            if ($urandom_range(9) == 0) send_noise();
            send_reply();
            if ($urandom_range(9) == 0) send_noise();
            if ($urandom_range(99) < 85) send_reply();
         end
      end
   endtask

   task automatic settle_block();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fetch_enable(input bit value);
      csr_chan.valid        <= 1'b1;
      csr_chan.fetch_enable <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      fetch_on = value;
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 51;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 51;
         end
         default: begin
            sender_idle_pct    = 26;
            receiver_stall_pct = 26;
         end
      endcase
   endtask

   task automatic change_phase(input int phase);
      bit mid_fetch;
      // leave a screen fetch open across the control write where the beam allows
      mid_fetch = fetch_on && beam_in_window();
      if (mid_fetch) send_tick();
      settle_block();
      write_fetch_enable(phase % 3 != 2);
      set_idling(phase);
      if (mid_fetch) begin
         send_reply();
         send_reply();
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.kind         <= KIND_BUS_WRITE;
      req_chan.bus_addr     <= '0;
      req_chan.data         <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.fetch_enable <= 1'b1;
      beam_col      = 0;
      beam_line     = 0;
      frame_wrapped = 1'b0;
      fetch_on      = 1'b1;
      set_idling(0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_fetch_enable(1'b1);

      send_item(KIND_BUS_WRITE, {12'hFFF, REG_CONTROL_ONE}, 8'hFF);
      send_item(KIND_BUS_WRITE, {12'h000, REG_CONTROL_TWO}, 8'hA5);
      send_item(KIND_BUS_WRITE, {12'h800, REG_RASTER}, 8'h5A);
      send_item(KIND_BUS_WRITE, {12'h123, REG_BACKGROUND}, 8'hFF);
      send_item(KIND_BUS_WRITE, {12'h000, REG_BORDER}, 8'h0E);
      send_item(KIND_BUS_WRITE, {12'h000, REG_SCREEN_BASE}, 8'hFF);
      send_item(KIND_BUS_WRITE, {12'hFFF, REG_GLYPH_BASE}, 8'h00);
      // first unmapped select, then the top of the address space
      send_item(KIND_BUS_WRITE, {12'h000, REG_GLYPH_BASE + 4'd1}, 8'h55);
      send_item(KIND_BUS_WRITE, 16'hFFFF, 8'hAA);
      for (int sel = 0; sel <= int'(REG_GLYPH_BASE) + 1; sel++) begin
         send_item(KIND_BUS_READ, {12'h5A5, 4'(sel)}, 8'h00);
      end
      send_item(KIND_BUS_READ, 16'hFFFF, 8'hFF);
      send_item(KIND_FETCH_REPLY, 16'h0000, 8'hC3);
      send_item(KIND_PIXEL_TICK, 16'hFFFF, 8'hFF);
      send_item(KIND_FETCH_REPLY, 16'hFFFF, 8'h00);
      send_item(KIND_PIXEL_TICK, 16'h0000, 8'h00);
      settle_block();

      for (int step = 0; !frame_wrapped; step++) begin
         if (step != 0 && step % STEPS_PER_PHASE == 0) change_phase(step / STEPS_PER_PHASE);
         raster_step();
      end

      settle_block();
      if (fail_count == 0) begin
         $display("PASS character_raster_video_generator");
      end else begin
         $display("FAIL character_raster_video_generator");
      end
      $finish;
   end

endmodule : tb_character_raster_video_generator
